// File: rtl/core/cfp_pkg.sv
// Shared widths, constants and sequencer states for the closest factor pair core.
package cfp_pkg;

    // Width of the number as it is used by the datapath.
    localparam int NUM_WIDTH   = 24;
    // Fixed field widths of the ports.
    localparam int IN_WIDTH    = 24;
    localparam int LARGE_WIDTH = 24;
    localparam int SMALL_WIDTH = 12;

    // Floor root of a NUM_WIDTH-bit value fits in this many bits.
    localparam int ROOT_WIDTH  = (NUM_WIDTH + 1) / 2;
    // Step counters of the two iterative units.
    localparam int ROOT_CNT_W  = $clog2(ROOT_WIDTH);
    localparam int DIV_CNT_W   = $clog2(NUM_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_TRY,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// File: rtl/core/cfp_isqrt.sv
// Bit-serial exact floor square root, one root bit per cycle.
module cfp_isqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [cfp_pkg::NUM_WIDTH-1:0]  radicand,
    output logic                           done,
    output logic [cfp_pkg::ROOT_WIDTH-1:0] root
);
    import cfp_pkg::*;

    localparam int SRC_W = 2 * ROOT_WIDTH;
    localparam int REM_W = ROOT_WIDTH + 3;

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SRC_W-1:0]      src_reg, src_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_WIDTH-1:0] root_reg, root_next;

    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic                  fits;

    always_comb begin
        // bring down the next pair of radicand bits
        rem_sh = {rem_reg[REM_W-3:0], src_reg[SRC_W-1 -: 2]};
        trial  = REM_W'({root_reg, 2'b01});
        fits   = (rem_sh >= trial);

        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        src_next    = src_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;

        if (start) begin
            active_next = 1'b1;
            cnt_next    = '0;
            src_next    = SRC_W'(radicand);
            rem_next    = '0;
            root_next   = '0;
        end else if (active_reg) begin
            src_next  = {src_reg[SRC_W-3:0], 2'b00};
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[ROOT_WIDTH-2:0], fits};
            cnt_next  = cnt_reg + ROOT_CNT_W'(1);
            if (cnt_reg == ROOT_CNT_W'(ROOT_WIDTH - 1)) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
        cnt_reg  <= cnt_next;
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/core/cfp_divider.sv
// Restoring divider, one quotient bit per cycle.
module cfp_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [cfp_pkg::NUM_WIDTH-1:0]  dividend,
    input  logic [cfp_pkg::ROOT_WIDTH-1:0] divisor,
    output logic                           done,
    output logic [cfp_pkg::NUM_WIDTH-1:0]  quotient,
    output logic [cfp_pkg::ROOT_WIDTH-1:0] remainder
);
    import cfp_pkg::*;

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_WIDTH-1:0]  quo_reg, quo_next;
    logic [ROOT_WIDTH-1:0] rem_reg, rem_next;
    logic [ROOT_WIDTH-1:0] dvs_reg, dvs_next;

    logic [ROOT_WIDTH:0]   rem_sh;
    logic [ROOT_WIDTH:0]   diff;
    logic                  qbit;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[NUM_WIDTH-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        // no borrow: the divisor fits
        qbit   = ~diff[ROOT_WIDTH];

        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;

        if (start) begin
            active_next = 1'b1;
            cnt_next    = '0;
            quo_next    = dividend;
            rem_next    = '0;
            dvs_next    = divisor;
        end else if (active_reg) begin
            quo_next = {quo_reg[NUM_WIDTH-2:0], qbit};
            rem_next = qbit ? diff[ROOT_WIDTH-1:0] : rem_sh[ROOT_WIDTH-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(NUM_WIDTH - 1)) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/closest_factor_pair_core.sv
// Top level: splits a number into its most nearly square factor pair.
//
// Input channel s_valid/s_ready/s_number carries one word, the number.
// Result channel m_valid/m_ready/m_larger_factor/m_smaller_factor carries one
// word per input word: the largest divisor not above floor(sqrt(number)) and
// the matching cofactor. A zero input gives both factors as zero.
//
// Sequence: the floor root step (launch, ROOT_WIDTH = 12 root bits, done)
// runs first, then each candidate divisor, counting down from the root, is
// tried in the shared restoring divider (NUM_WIDTH quotient bits) until one
// divides the number; m_valid then rises once the result reaches the output
// register. A zero input skips both steps. A prime near 2^24 tries about
// 4096 candidates. s_ready is high only while the sequencer is idle, so a
// new word is taken only once the previous result has moved to the output
// register.
//
// The result sits in an output register, so a new word is accepted while the
// previous result still waits; if the receiver stalls, the next finished
// result waits in the sequencer until the output register frees up.
// aresetn is synchronous, active low, and drops any word in flight.
module closest_factor_pair_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cfp_pkg::IN_WIDTH-1:0]    s_number,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cfp_pkg::LARGE_WIDTH-1:0] m_larger_factor,
    output logic [cfp_pkg::SMALL_WIDTH-1:0] m_smaller_factor
);
    import cfp_pkg::*;

    state_t                 state_reg, state_next;
    logic [NUM_WIDTH-1:0]   n_reg, n_next;
    logic [ROOT_WIDTH-1:0]  d_reg, d_next;
    logic [NUM_WIDTH-1:0]   res_large_reg, res_large_next;
    logic [ROOT_WIDTH-1:0]  res_small_reg, res_small_next;
    logic                   m_valid_reg, m_valid_next;
    logic [LARGE_WIDTH-1:0] m_large_reg, m_large_next;
    logic [SMALL_WIDTH-1:0] m_small_reg, m_small_next;
    // root unit is started the cycle after the word lands in n_reg
    logic                   root_pend_reg;

    logic                   in_fire;
    logic [NUM_WIDTH-1:0]   in_num;
    logic                   root_start, root_done;
    logic [ROOT_WIDTH-1:0]  root_val;
    logic                   div_start, div_done;
    logic [NUM_WIDTH-1:0]   div_quo;
    logic [ROOT_WIDTH-1:0]  div_rem;

    cfp_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (n_reg),
        .done     (root_done),
        .root     (root_val)
    );

    cfp_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign in_num  = NUM_WIDTH'(s_number);

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        res_large_next = res_large_reg;
        res_small_next = res_small_reg;
        m_valid_next   = m_valid_reg;
        m_large_next   = m_large_reg;
        m_small_next   = m_small_reg;
        root_start     = 1'b0;
        div_start      = 1'b0;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    n_next = in_num;
                    if (in_num == '0) begin
                        // zero has no divisor: report 0 / 0
                        res_large_next = '0;
                        res_small_next = '0;
                        state_next     = ST_OUT;
                    end else begin
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                // root unit launched on entry, n_reg is stable here
                root_start = root_pend_reg;
                if (root_done) begin
                    d_next     = root_val;
                    state_next = ST_TRY;
                end
            end
            ST_TRY: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        res_large_next = div_quo;
                        res_small_next = d_reg;
                        state_next     = ST_OUT;
                    end else begin
                        // d = 1 always divides, so this never reaches zero
                        d_next     = d_reg - ROOT_WIDTH'(1);
                        state_next = ST_TRY;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_large_next = LARGE_WIDTH'(res_large_reg);
                    m_small_next = SMALL_WIDTH'(res_small_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            root_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            root_pend_reg <= (state_reg == ST_IDLE) && (state_next == ST_ROOT);
        end
        n_reg         <= n_next;
        d_reg         <= d_next;
        res_large_reg <= res_large_next;
        res_small_reg <= res_small_next;
        m_large_reg   <= m_large_next;
        m_small_reg   <= m_small_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_larger_factor  = m_large_reg;
    assign m_smaller_factor = m_small_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------

    // a candidate divisor is never zero once trial division is running
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TRY || state_reg == ST_DIV) |-> (d_reg != '0))
        else $error("trial divisor reached zero");

    // a zero smaller factor only ever comes with a zero larger factor
    a_zero_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_smaller_factor != '0 || m_larger_factor == '0))
        else $error("zero divisor with nonzero cofactor");

    // the root unit and the divider never finish together
    a_unit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(root_done && div_done))
        else $error("root and divider done in the same cycle");

    // a divide is only launched from the try step
    a_div_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> (state_reg == ST_DIV))
        else $error("divider started outside trial sequence");

endmodule
